[src/imu_fp_pkg.sv]
// Shared types and constants for the IMU frame parser.
package imu_fp_pkg;

  localparam logic [7:0]  HDR_BYTE       = 8'h55;
  localparam logic [7:0]  TYPE_ACCEL     = 8'h51;
  localparam logic [7:0]  TYPE_RATE      = 8'h52;
  localparam logic [7:0]  TYPE_ANGLE     = 8'h53;
  localparam int unsigned FRAME_LEN      = 11;
  localparam int unsigned FRAME_STORE    = FRAME_LEN - 2;
  localparam int unsigned NUM_SENS       = 10;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
  localparam logic [15:0] AGE_MAX        = 16'hFFFF;

  localparam int unsigned CNT_W = $clog2(FRAME_LEN);
  localparam int unsigned FIDX_W = $clog2(FRAME_STORE);
  localparam int unsigned SIDX_W = $clog2(NUM_SENS);

  localparam logic [CNT_W-1:0] CNT_LAST_DATA = CNT_W'(FRAME_LEN - 2);

  localparam logic [SIDX_W-1:0] SV_ACC_X = SIDX_W'(0);
  localparam logic [SIDX_W-1:0] SV_RATE_X = SIDX_W'(3);
  localparam logic [SIDX_W-1:0] SV_ROLL = SIDX_W'(6);
  localparam logic [SIDX_W-1:0] SV_PITCH = SIDX_W'(7);
  localparam logic [SIDX_W-1:0] SV_YAW = SIDX_W'(8);
  localparam logic [SIDX_W-1:0] SV_TEMP = SIDX_W'(9);

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_e;

  localparam int unsigned ST_READY = 0;
  localparam int unsigned ST_ALIVE = 1;
  localparam int unsigned ST_GOOD  = 2;
  localparam int unsigned ST_BAD   = 3;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] temperature_raw;
    logic [3:0]         status_flags;
  } result_t;

endpackage

[src/imu_frame_parser.sv]
// Top level of the IMU frame parser: parser core and buffered result channel.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    op_i, rx_byte_i
//   out      out_valid_o / out_ready_i  accel_*, rate_*, *_raw, status_flags_o
//   cfg      cfg_we_i                   cfg_wdata_i (alive timeout, ms)
//
// One item per cycle while in_ready_o is high; each transfer yields one result.
// State updates in the transfer cycle; the result register and a skid stage
// hold up to two results, so in_ready_o drops only when both are full.
// Reset clears the parser state, the timeout to 500 and the result channel.
module imu_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic signed [15:0] roll_raw_o,
  output logic signed [15:0] pitch_raw_o,
  output logic signed [15:0] yaw_raw_o,
  output logic signed [15:0] temperature_raw_o,
  output logic [3:0]         status_flags_o
);
  import imu_fp_pkg::*;

  logic    take;
  result_t res, res_out;

  assign take = in_valid_i && in_ready_o;

  imu_fp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .op_i        (op_i),
    .rx_byte_i   (rx_byte_i),
    .result_o    (res)
  );

  imu_fp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign accel_x_o         = res_out.accel_x;
  assign accel_y_o         = res_out.accel_y;
  assign accel_z_o         = res_out.accel_z;
  assign rate_x_o          = res_out.rate_x;
  assign rate_y_o          = res_out.rate_y;
  assign rate_z_o          = res_out.rate_z;
  assign roll_raw_o        = res_out.roll_raw;
  assign pitch_raw_o       = res_out.pitch_raw;
  assign yaw_raw_o         = res_out.yaw_raw;
  assign temperature_raw_o = res_out.temperature_raw;
  assign status_flags_o    = res_out.status_flags;

endmodule

[src/imu_fp_parser.sv]
// Frame parser core: byte hunt, running checksum, sensor value store and link age.
module imu_fp_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     take_i,
  input  logic [1:0]               op_i,
  input  logic [7:0]               rx_byte_i,
  output imu_fp_pkg::result_t      result_o
);
  import imu_fp_pkg::*;

  logic [15:0]       timeout_q;
  logic              collecting_q, collecting_d;
  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [7:0]        running_sum_q, running_sum_d;
  logic [7:0]        frame_q [FRAME_STORE];
  logic [15:0]       sens_q [NUM_SENS];
  logic [15:0]       sens_d [NUM_SENS];
  logic              ready_q, ready_d;
  logic              seen_q, seen_d;
  logic [15:0]       age_q, age_d;
  logic              frame_we;
  logic [FIDX_W-1:0] frame_idx;
  logic              good, bad;
  logic [15:0]       le0, le1, le2, le3;
  logic [7:0]        ftype;

  assign ftype     = frame_q[0];
  assign le0       = {frame_q[2], frame_q[1]};
  assign le1       = {frame_q[4], frame_q[3]};
  assign le2       = {frame_q[6], frame_q[5]};
  assign le3       = {frame_q[8], frame_q[7]};
  assign frame_idx = FIDX_W'(byte_count_q - CNT_W'(1));

  always_comb begin
    collecting_d  = collecting_q;
    byte_count_d  = byte_count_q;
    running_sum_d = running_sum_q;
    sens_d        = sens_q;
    ready_d       = ready_q;
    seen_d        = seen_q;
    age_d         = age_q;
    frame_we      = 1'b0;
    good          = 1'b0;
    bad           = 1'b0;
    case (op_i)
      OP_BYTE: begin
        if (!collecting_q) begin
          if (rx_byte_i == HDR_BYTE) begin
            collecting_d  = 1'b1;
            byte_count_d  = CNT_W'(1);
            running_sum_d = HDR_BYTE;
          end
        end else if (byte_count_q >= CNT_W'(1) && byte_count_q <= CNT_LAST_DATA) begin
          frame_we      = 1'b1;
          running_sum_d = running_sum_q + rx_byte_i;
          byte_count_d  = byte_count_q + CNT_W'(1);
        end else begin
          if (running_sum_q == rx_byte_i) begin
            good = 1'b1;
            if (ftype == TYPE_ACCEL || ftype == TYPE_RATE) begin
              if (ftype == TYPE_ACCEL) begin
                sens_d[SV_ACC_X]               = le0;
                sens_d[SV_ACC_X + SIDX_W'(1)]  = le1;
                sens_d[SV_ACC_X + SIDX_W'(2)]  = le2;
              end else begin
                sens_d[SV_RATE_X]              = le0;
                sens_d[SV_RATE_X + SIDX_W'(1)] = le1;
                sens_d[SV_RATE_X + SIDX_W'(2)] = le2;
              end
              sens_d[SV_TEMP] = le3;
            end else if (ftype == TYPE_ANGLE) begin
              sens_d[SV_ROLL]  = le0;
              sens_d[SV_PITCH] = le1;
              sens_d[SV_YAW]   = le2;
              ready_d          = 1'b1;
              seen_d           = 1'b1;
              age_d            = '0;
            end
          end else begin
            bad = 1'b1;
          end
          collecting_d  = 1'b0;
          byte_count_d  = '0;
          running_sum_d = '0;
        end
      end
      OP_TICK: begin
        if (age_q != AGE_MAX) begin
          age_d = age_q + 16'd1;
        end
      end
      OP_READ: begin
        ready_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.accel_x         = sens_d[0];
    result_o.accel_y         = sens_d[1];
    result_o.accel_z         = sens_d[2];
    result_o.rate_x          = sens_d[3];
    result_o.rate_y          = sens_d[4];
    result_o.rate_z          = sens_d[5];
    result_o.roll_raw        = sens_d[6];
    result_o.pitch_raw       = sens_d[7];
    result_o.yaw_raw         = sens_d[8];
    result_o.temperature_raw = sens_d[9];
    result_o.status_flags[ST_READY] = (op_i == OP_READ) ? ready_q : ready_d;
    result_o.status_flags[ST_ALIVE] = seen_d && (age_d < timeout_q);
    result_o.status_flags[ST_GOOD]  = good;
    result_o.status_flags[ST_BAD]   = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q  <= 1'b0;
      byte_count_q  <= '0;
      running_sum_q <= '0;
      ready_q       <= 1'b0;
      seen_q        <= 1'b0;
      age_q         <= '0;
      for (int i = 0; i < NUM_SENS; i++) begin
        sens_q[i] <= '0;
      end
    end else if (take_i) begin
      collecting_q  <= collecting_d;
      byte_count_q  <= byte_count_d;
      running_sum_q <= running_sum_d;
      ready_q       <= ready_d;
      seen_q        <= seen_d;
      age_q         <= age_d;
      sens_q        <= sens_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && frame_we) begin
      frame_q[frame_idx] <= rx_byte_i;
    end
  end

endmodule

[src/imu_fp_out_buf.sv]
// Result register with a skid stage between the parser and the output channel.
module imu_fp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  imu_fp_pkg::result_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output imu_fp_pkg::result_t data_o
);
  import imu_fp_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule
